// ===== hw/rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sidechain pump ducker package
// Shared widths, configuration register indexes and the unity gain constant.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    localparam int GAIN_BITS    = 17;
    localparam int POS_BITS     = 48;
    localparam int CFG_IDX_BITS = 3;

    // Unity gain in Q1.16.
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENABLE    = 3'd0;
    localparam t_cfg_idx CFG_SYNC_MODE = 3'd1;
    localparam t_cfg_idx CFG_PHASE_INC = 3'd2;
    localparam t_cfg_idx CFG_DEPTH     = 3'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/spd_in_if.sv =====
// ----------------------------------------------------------------------------
// Sidechain pump ducker input channel
// Valid/ready channel carrying one stereo frame and its block timing.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import spd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_start;
    logic [POS_BITS-1:0]           timeline_position;

    modport source (
        output valid, left_in, right_in, block_start, timeline_position,
        input  ready
    );

    modport sink (
        input  valid, left_in, right_in, block_start, timeline_position,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/spd_out_if.sv =====
// ----------------------------------------------------------------------------
// Sidechain pump ducker output channel
// Valid/ready channel carrying one scaled stereo frame and the gain used.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_out_if #(
    parameter int SAMPLE_BITS = 24
);
    import spd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_BITS-1:0]          gain_applied;

    modport source (
        output valid, left_out, right_out, gain_applied,
        input  ready
    );

    modport sink (
        input  valid, left_out, right_out, gain_applied,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/spd_mac.sv =====
// ----------------------------------------------------------------------------
// Sidechain pump ducker multiply-add unit
// Registered signed multiply with an added constant, shared by every product.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_mac #(
    parameter int OP_W = 26
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [OP_W-1:0]   i_a,
    input  wire logic signed [OP_W-1:0]   i_b,
    input  wire logic signed [2*OP_W-1:0] i_add,
    output logic signed [2*OP_W-1:0]      o_prod
);

    logic signed [2*OP_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b + i_add;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hw/rtl/sidechain_pump_ducker.sv =====
// ----------------------------------------------------------------------------
// Sidechain pump ducker
// Applies a quadratic pump gain to a stereo stream using one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// Frames enter on s_in and leave on m_out, one result per frame. A frame is
// transferred when valid and ready are both high. The block takes one frame
// at a time: s_in.ready is high only while the sequencer is idle.
// With ducking enabled a frame steps through S_SQ, S_DIP, S_GAIN, S_LEFT,
// S_RIGHT and S_FIN before its result is offered, and the next frame is taken
// only after S_FIN; a block start that reloads the phase in sync mode adds
// S_SYNC and S_LDPH before S_SQ. Every product (sync reload, shape squared,
// depth scaling, left and right samples) goes through the single multiply-add
// unit one after the other. A disabled block passes the frame through S_PASS
// and takes the next frame once that state is done.
// Results sit in an output register, so a stalled receiver only holds the
// sequencer at its last step; the next frame is taken once that result moves.
// The user must write configuration via i_cfg_we / i_cfg_index / i_cfg_data only
// while the block is idle (not enforced). Writing enable 0 to 1 clears the phase.
// Synchronous reset clears the configuration, the phase and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sidechain_pump_ducker #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 24,
    localparam int CFG_W      = (PHASE_BITS > 17) ? PHASE_BITS : 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire spd_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    spd_in_if.sink                 s_in,
    spd_out_if.source              m_out
);
    import spd_pkg::*;

    localparam int OP_W = (PHASE_BITS + 2 > SAMPLE_BITS) ? PHASE_BITS + 2 : SAMPLE_BITS;
    localparam int PW   = 2 * OP_W;

    localparam logic [PHASE_BITS:0]  PH_ONE   = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic signed [PW-1:0] PH_HALF  = PW'(PH_ONE >> 1);
    localparam logic signed [PW-1:0] RND_HALF = PW'(32'sd32768);

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_SYNC  = 4'd2;
    localparam logic [3:0] S_LDPH  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_DIP   = 4'd5;
    localparam logic [3:0] S_GAIN  = 4'd6;
    localparam logic [3:0] S_LEFT  = 4'd7;
    localparam logic [3:0] S_RIGHT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // Configuration and state.
    logic                   r_enable;
    logic                   r_sync;
    logic [PHASE_BITS-1:0]  r_inc;
    logic [GAIN_BITS-1:0]   r_depth;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [3:0]             r_state;

    // Frame under work.
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic [PHASE_BITS-1:0]         r_pos_lo;
    logic [GAIN_BITS-1:0]          r_gain;
    logic signed [SAMPLE_BITS-1:0] r_left_res;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;
    logic [GAIN_BITS-1:0]          r_gain_out;

    logic                   mac_en;
    logic signed [OP_W-1:0] mac_a;
    logic signed [OP_W-1:0] mac_b;
    logic signed [PW-1:0]   mac_add;
    logic signed [PW-1:0]   mac_prod;

    logic [PHASE_BITS:0]           shape;
    logic [PHASE_BITS:0]           sq;
    logic                          sat_ovf;
    logic signed [SAMPLE_BITS-1:0] sat_res;
    logic [GAIN_BITS-1:0]          n_gain;
    logic                          out_free;
    logic                          out_load;

    spd_mac #(
        .OP_W (OP_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (mac_en),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .i_add  (mac_add),
        .o_prod (mac_prod)
    );

    assign shape = PH_ONE - {1'b0, r_phase};
    assign sq    = mac_prod[2*PHASE_BITS:PHASE_BITS];

    // The rounded dip is the product above the phase fraction; any bit at or
    // above unity gain forces the gain to zero.
    assign n_gain = (mac_prod[PW-1:PHASE_BITS+16] != '0) ? '0 :
                    GAIN_ONE - {1'b0, mac_prod[PHASE_BITS+15:PHASE_BITS]};

    // Saturate the rounded sample product, already biased by one half LSB.
    assign sat_ovf = !((&mac_prod[PW-1:SAMPLE_BITS+15]) || !(|mac_prod[PW-1:SAMPLE_BITS+15]));
    assign sat_res = sat_ovf ? (mac_prod[PW-1] ? S_MIN : S_MAX) : mac_prod[SAMPLE_BITS+15:16];

    assign out_free = !r_out_valid || m_out.ready;
    assign out_load = ((r_state == S_PASS) || (r_state == S_FIN)) && out_free;

    always_comb begin
        mac_en  = 1'b0;
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        unique case (r_state)
            S_SYNC: begin
                mac_en = 1'b1;
                mac_a  = OP_W'(r_pos_lo);
                mac_b  = OP_W'(r_inc);
            end
            S_SQ: begin
                mac_en  = 1'b1;
                mac_a   = OP_W'(shape);
                mac_b   = OP_W'(shape);
                mac_add = PH_HALF;
            end
            S_DIP: begin
                mac_en  = 1'b1;
                mac_a   = OP_W'(r_depth);
                mac_b   = OP_W'(sq);
                mac_add = PH_HALF;
            end
            S_LEFT: begin
                mac_en  = 1'b1;
                mac_a   = OP_W'(r_left);
                mac_b   = OP_W'(r_gain);
                mac_add = RND_HALF;
            end
            S_RIGHT: begin
                mac_en  = 1'b1;
                mac_a   = OP_W'(r_right);
                mac_b   = OP_W'(r_gain);
                mac_add = RND_HALF;
            end
            default: begin
                mac_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_sync      <= 1'b0;
            r_inc       <= '0;
            r_depth     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_left   <= s_in.left_in;
                        r_right  <= s_in.right_in;
                        r_pos_lo <= s_in.timeline_position[PHASE_BITS-1:0];
                        if (!r_enable) begin
                            r_gain  <= GAIN_ONE;
                            r_state <= S_PASS;
                        end else if (r_sync && s_in.block_start) begin
                            r_state <= S_SYNC;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_PASS: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SYNC: begin
                    r_state <= S_LDPH;
                end
                S_LDPH: begin
                    r_phase <= mac_prod[PHASE_BITS-1:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_DIP;
                end
                S_DIP: begin
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_gain  <= n_gain;
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    r_state <= S_RIGHT;
                end
                S_RIGHT: begin
                    r_left_res <= sat_res;
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_phase <= r_phase + r_inc;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // Writes must arrive only while the sequencer is idle; the block does not enforce it.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (i_cfg_data[0] && !r_enable) begin
                            r_phase <= '0;
                        end
                    end
                    CFG_SYNC_MODE: begin
                        r_sync <= i_cfg_data[0];
                    end
                    CFG_PHASE_INC: begin
                        r_inc <= i_cfg_data[PHASE_BITS-1:0];
                    end
                    CFG_DEPTH: begin
                        r_depth <= i_cfg_data[GAIN_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_PASS) begin
                r_left_out  <= r_left;
                r_right_out <= r_right;
            end else begin
                r_left_out  <= r_left_res;
                r_right_out <= sat_res;
            end
            r_gain_out <= r_gain;
        end
    end

    assign s_in.ready         = (r_state == S_IDLE);
    assign m_out.valid        = r_out_valid;
    assign m_out.left_out     = r_left_out;
    assign m_out.right_out    = r_right_out;
    assign m_out.gain_applied = r_gain_out;

endmodule

`default_nettype wire
